// ===== rtl/owm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// Shared constants and types of the one-edit word matcher: store sizes,
// the job record that runs from front to back, and the walk read request.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int SYM_W   = 8;
	localparam int CNT_W   = 32;
	localparam int QDEPTH  = 2;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		JOB_CLEAR,
		JOB_REJECT,
		JOB_MATCH,
		JOB_WALK
	} job_kind_t;

	typedef enum logic [1:0] {
		LEN_EQUAL,
		LEN_LONGER,
		LEN_SHORTER
	} len_rel_t;

	typedef struct packed {
		job_kind_t kind;
		len_rel_t  rel;
		len_t      w_len;
		len_t      r_len;
		len_t      prefix;
	} job_t;

	typedef struct packed {
		logic  rd;
		addr_t w_addr;
		addr_t r_addr;
	} walk_rd_t;

endpackage

// ===== rtl/owm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module owm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/owm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module owm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  owm_pkg::job_t din,
	output logic          full,
	input  logic          rd,
	output owm_pkg::job_t dout,
	output logic          empty
);
	import owm_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FILL_W = $clog2(QDEPTH + 1);

	job_t              slot_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (fill_q == FILL_W'(QDEPTH));
	assign empty = (fill_q == '0);
	assign dout  = slot_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_W'(QDEPTH))
		else $error("job queue fill above depth");

endmodule

// ===== rtl/owm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_front
// Accepts symbol requests, fills the reference and word stores, tracks the
// common prefix and classifies each finished candidate into a job.
// ----------------------------------------------------------------------------
module owm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic           mode,
	input  owm_pkg::sym_t  symbol,
	input  logic           last,
	output logic           ref_we,
	output owm_pkg::addr_t ref_waddr,
	output owm_pkg::addr_t ref_raddr,
	input  owm_pkg::sym_t  ref_rdata,
	output logic           word_we,
	output owm_pkg::addr_t word_waddr,
	output owm_pkg::sym_t  wdata,
	output logic           job_push,
	output owm_pkg::job_t  job,
	input  logic           job_full,
	input  logic           release_walk
);
	import owm_pkg::*;

	localparam len_t LEN_MAX = LEN_W'(MAX_LEN);
	localparam len_t LEN_ONE = LEN_W'(1);

	logic accept;
	logic s1_valid_q;
	logic mode_s1;
	sym_t sym_s1;
	logic last_s1;

	len_t ref_len_q;
	logic ref_open_q;
	logic ref_ovf_q;
	len_t word_len_q;
	len_t prefix_q;
	logic prefix_open_q;
	logic word_ovf_q;
	logic pending_q;

	len_t ref_base;
	logic w_stored;
	logic pref_hit;
	len_t w_new;
	len_t p_new;
	logic wovf_new;

	assign full     = s1_valid_q || pending_q || job_full;
	assign accept   = push && !full;
	assign ref_base = ref_open_q ? ref_len_q : '0;

	assign ref_we     = accept && !mode && (ref_base < LEN_MAX);
	assign ref_waddr  = ref_base[ADDR_W-1:0];
	assign word_we    = accept && mode && (word_len_q < LEN_MAX);
	assign word_waddr = word_len_q[ADDR_W-1:0];
	assign ref_raddr  = word_len_q[ADDR_W-1:0];
	assign wdata      = symbol;

	always_comb begin
		w_stored = (word_len_q < LEN_MAX);
		pref_hit = prefix_open_q && (word_len_q < ref_len_q) && (ref_rdata == sym_s1);
		w_new    = w_stored ? word_len_q + LEN_ONE : word_len_q;
		p_new    = (w_stored && pref_hit) ? prefix_q + LEN_ONE : prefix_q;
		wovf_new = word_ovf_q || !w_stored;

		job        = '0;
		job.w_len  = w_new;
		job.r_len  = ref_len_q;
		job.prefix = p_new;
		job.rel    = LEN_EQUAL;
		if (!mode_s1) begin
			job.kind = JOB_CLEAR;
		end else if (wovf_new || ref_ovf_q || (w_new == '0)) begin
			job.kind = JOB_REJECT;
		end else if (w_new == ref_len_q) begin
			job.kind = (p_new == w_new) ? JOB_MATCH : JOB_WALK;
		end else if (w_new == ref_len_q + LEN_ONE) begin
			job.kind = JOB_WALK;
			job.rel  = LEN_LONGER;
		end else if (w_new + LEN_ONE == ref_len_q) begin
			job.kind = JOB_WALK;
			job.rel  = LEN_SHORTER;
		end else begin
			job.kind = JOB_REJECT;
		end

		job_push = s1_valid_q && (mode_s1 ? last_s1 : !ref_open_q);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			sym_s1  <= symbol;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			ref_len_q     <= '0;
			ref_open_q    <= 1'b0;
			ref_ovf_q     <= 1'b0;
			word_len_q    <= '0;
			prefix_q      <= '0;
			prefix_open_q <= 1'b1;
			word_ovf_q    <= 1'b0;
			pending_q     <= 1'b0;
		end else begin
			if (release_walk) begin
				pending_q <= 1'b0;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_valid_q) begin
				s1_valid_q <= 1'b0;
				if (!mode_s1) begin
					// reference symbol drops any partial candidate
					word_len_q    <= '0;
					prefix_q      <= '0;
					prefix_open_q <= 1'b1;
					word_ovf_q    <= 1'b0;
					ref_len_q     <= (ref_base < LEN_MAX) ? ref_base + LEN_ONE : ref_base;
					ref_ovf_q     <= (ref_open_q && ref_ovf_q) || !(ref_base < LEN_MAX);
					ref_open_q    <= !last_s1;
				end else begin
					ref_open_q <= 1'b0;
					if (last_s1) begin
						word_len_q    <= '0;
						prefix_q      <= '0;
						prefix_open_q <= 1'b1;
						word_ovf_q    <= 1'b0;
						// hold the stores until the back has walked them
						pending_q     <= (job.kind == JOB_WALK);
					end else begin
						word_len_q    <= w_new;
						prefix_q      <= p_new;
						prefix_open_q <= w_stored ? pref_hit : prefix_open_q;
						word_ovf_q    <= wovf_new;
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) s1_valid_q |=> !s1_valid_q)
		else $error("compare stage held two cycles");
	assert property (@(posedge clk) disable iff (!arst_n) prefix_q <= word_len_q)
		else $error("prefix longer than word");
	assert property (@(posedge clk) disable iff (!arst_n) pending_q |-> !s1_valid_q)
		else $error("request taken while stores are locked");

endmodule

// ===== rtl/owm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_back
// Runs jobs from the queue: walks both stores backward for the common
// suffix, judges the candidate and keeps the saturating match count.
// ----------------------------------------------------------------------------
module owm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  owm_pkg::job_t     job,
	input  logic              job_empty,
	output logic              job_pop,
	output owm_pkg::walk_rd_t rd,
	input  owm_pkg::sym_t     word_rdata,
	input  owm_pkg::sym_t     ref_rdata,
	output logic              release_walk,
	output logic              empty,
	input  logic              pop,
	output logic              similar,
	output owm_pkg::cnt_t     similar_count
);
	import owm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_FIN
	} state_t;

	state_t st_q;
	job_t   job_q;
	len_t   n_q;
	len_t   lim_q;
	logic   sim_q;
	cnt_t   cnt_q;
	logic   out_valid_q;
	logic   similar_q;
	cnt_t   out_cnt_q;
	logic   rel_q;

	len_t lim;
	len_t n_inc;
	logic hit;
	len_t w_idx;
	len_t r_idx;
	cnt_t cnt_next;
	logic walk_end;
	logic rel_next;
	logic fin_go;

	function automatic logic judge(job_t j, len_t n);
		logic [LEN_W:0] sum;
		logic [LEN_W:0] wl;
		sum = {1'b0, j.prefix} + {1'b0, n};
		wl  = {1'b0, j.w_len};
		case (j.rel)
			LEN_EQUAL:   judge = (sum == wl - (LEN_W + 1)'(1));
			LEN_LONGER:  judge = (sum >= wl - (LEN_W + 1)'(1));
			LEN_SHORTER: judge = (sum >= wl);
			default:     judge = 1'b0;
		endcase
	endfunction

	assign lim      = (job.w_len < job.r_len) ? job.w_len : job.r_len;
	assign n_inc    = n_q + LEN_W'(1);
	assign hit      = (word_rdata == ref_rdata);
	assign w_idx    = job_q.w_len - LEN_W'(1) - n_q;
	assign r_idx    = job_q.r_len - LEN_W'(1) - n_q;
	assign cnt_next = (sim_q && (cnt_q != '1)) ? cnt_q + CNT_W'(1) : cnt_q;

	// the walk ends on a mismatch or once the shorter word is used up
	assign walk_end = (st_q == S_CMP) && !(hit && (n_inc < lim_q));
	assign rel_next = (job_pop && (job.kind == JOB_WALK) && (lim == '0)) || walk_end;
	assign fin_go   = (st_q == S_FIN) && (!out_valid_q || pop);

	assign job_pop       = (st_q == S_IDLE) && !job_empty;
	assign rd.rd         = (st_q == S_RD);
	assign rd.w_addr     = w_idx[ADDR_W-1:0];
	assign rd.r_addr     = r_idx[ADDR_W-1:0];
	assign release_walk  = rel_q;
	assign empty         = !out_valid_q;
	assign similar       = similar_q;
	assign similar_count = out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			job_q       <= '0;
			n_q         <= '0;
			lim_q       <= '0;
			sim_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			similar_q   <= 1'b0;
			out_cnt_q   <= '0;
			rel_q       <= 1'b0;
		end else begin
			rel_q <= rel_next;
			if (pop && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (job_pop) begin
						job_q <= job;
						n_q   <= '0;
						lim_q <= lim;
						case (job.kind)
							JOB_CLEAR: cnt_q <= '0;
							JOB_REJECT: begin
								sim_q <= 1'b0;
								st_q  <= S_FIN;
							end
							JOB_MATCH: begin
								sim_q <= 1'b1;
								st_q  <= S_FIN;
							end
							JOB_WALK: begin
								if (lim == '0) begin
									sim_q <= judge(job, '0);
									st_q  <= S_FIN;
								end else begin
									st_q <= S_RD;
								end
							end
							default: st_q <= S_IDLE;
						endcase
					end
				end
				S_RD: st_q <= S_CMP;
				S_CMP: begin
					if (!walk_end) begin
						n_q  <= n_inc;
						st_q <= S_RD;
					end else begin
						sim_q <= judge(job_q, hit ? n_inc : n_q);
						st_q  <= S_FIN;
					end
				end
				S_FIN: begin
					// wait for the result slot
					if (fin_go) begin
						out_valid_q <= 1'b1;
						similar_q   <= sim_q;
						out_cnt_q   <= cnt_next;
						cnt_q       <= cnt_next;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) st_q == S_RD |=> st_q == S_CMP)
		else $error("read not followed by compare");
	assert property (@(posedge clk) disable iff (!arst_n) st_q == S_RD |-> n_q < lim_q)
		else $error("walk ran past the shorter word");
	assert property (@(posedge clk) disable iff (!arst_n) rel_q |-> st_q == S_FIN)
		else $error("stores released outside finish");

endmodule

// ===== rtl/one_edit_word_matcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_edit_word_matcher_unit
// One-edit-distance check of candidate words against a stored reference.
//
//   channel  handshake        payload
//   input    push / full      mode, symbol, last
//   result   pop / empty      similar, similar_count
//
// In the front each symbol is accepted with the store write and reference
// read, then goes on to the prefix compare.
// A candidate's last symbol that needs a suffix walk holds full high until
// the back has walked both stores, set by the single read port of each store.
// No clearing pass after reset; the stores are only read where written.
// A waiting result stalls the back; the front goes on until the job queue
// fills or a walk job waits behind it.
// ----------------------------------------------------------------------------
module one_edit_word_matcher_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          mode,
	input  owm_pkg::sym_t symbol,
	input  logic          last,
	output logic          empty,
	input  logic          pop,
	output logic          similar,
	output owm_pkg::cnt_t similar_count
);
	import owm_pkg::*;

	logic     ref_we;
	addr_t    ref_waddr;
	addr_t    front_raddr;
	addr_t    ref_raddr;
	sym_t     ref_rdata;
	logic     word_we;
	addr_t    word_waddr;
	sym_t     wdata;
	sym_t     word_rdata;
	logic     job_push;
	job_t     job_in;
	logic     job_full;
	job_t     job_out;
	logic     job_empty;
	logic     job_pop;
	walk_rd_t walk_rd;
	logic     release_walk;

	// back owns the reference read port while it walks
	assign ref_raddr = walk_rd.rd ? walk_rd.r_addr : front_raddr;

	owm_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (wdata),
		.raddr (ref_raddr),
		.rdata (ref_rdata)
	);

	owm_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (wdata),
		.raddr (walk_rd.w_addr),
		.rdata (word_rdata)
	);

	owm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.din    (job_in),
		.full   (job_full),
		.rd     (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	owm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.symbol       (symbol),
		.last         (last),
		.ref_we       (ref_we),
		.ref_waddr    (ref_waddr),
		.ref_raddr    (front_raddr),
		.ref_rdata    (ref_rdata),
		.word_we      (word_we),
		.word_waddr   (word_waddr),
		.wdata        (wdata),
		.job_push     (job_push),
		.job          (job_in),
		.job_full     (job_full),
		.release_walk (release_walk)
	);

	owm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (job_out),
		.job_empty     (job_empty),
		.job_pop       (job_pop),
		.rd            (walk_rd),
		.word_rdata    (word_rdata),
		.ref_rdata     (ref_rdata),
		.release_walk  (release_walk),
		.empty         (empty),
		.pop           (pop),
		.similar       (similar),
		.similar_count (similar_count)
	);

endmodule
